// ===== rtl/core/run_list_extent_decoder_macros.svh =====
// assertion helpers for the run list decoder
`ifndef RUN_LIST_EXTENT_DECODER_MACROS_SVH
`define RUN_LIST_EXTENT_DECODER_MACROS_SVH

// same-cycle implication, checked out of reset
`define RLED_ASSERT_NOW(label, ck, rstn, ante, cons) \
  label: assert property (@(posedge ck) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("run list decoder check failed");

// next-cycle implication, checked out of reset
`define RLED_ASSERT_NEXT(label, ck, rstn, ante, cons) \
  label: assert property (@(posedge ck) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("run list decoder check failed");

`endif

// ===== rtl/core/rled_pkg.sv =====
package rled_pkg;

  localparam int MAX_FIELD_BYTES = 8;

  typedef enum logic [1:0] {
    PH_HEADER = 2'd0,
    PH_LENGTH = 2'd1,
    PH_OFFSET = 2'd2
  } phase_t;

  typedef enum logic [1:0] {
    KIND_FRAG = 2'd0,
    KIND_END  = 2'd1,
    KIND_ERR  = 2'd2
  } kind_t;

  typedef struct packed {
    phase_t      phase;
    logic [3:0]  len_left;
    logic [3:0]  off_left;
    logic [3:0]  off_size;
    logic [2:0]  byte_pos;
    logic [63:0] len_acc;
    logic [63:0] off_acc;
    logic [63:0] run_start;
    logic [15:0] run_cnt;
  } parse_state_t;

  typedef struct packed {
    kind_t       kind;
    logic [15:0] run_num;
    logic [63:0] start;
    logic [63:0] count;
    logic [63:0] end_clu;
    logic [63:0] delta;
  } result_t;

  localparam parse_state_t STATE_CLEAR = '{phase: PH_HEADER, default: '0};

endpackage

// ===== rtl/core/rled_step.sv =====
module rled_step (
  input  rled_pkg::parse_state_t st,
  input  logic [7:0]             list_byte,
  output rled_pkg::parse_state_t st_nxt,
  output rled_pkg::result_t      res,
  output logic                   res_valid
);

  logic [3:0]  hdr_lo;
  logic [3:0]  hdr_hi;
  logic        hdr_bad;
  logic        hdr_end;
  logic [5:0]  lane_sh;
  logic [63:0] byte_lane;
  logic [63:0] len_new;
  logic [63:0] off_new;
  logic [3:0]  len_left_dec;
  logic [3:0]  off_left_dec;
  logic [5:0]  ext_sh;
  logic        ext_on;
  logic [63:0] delta;
  logic [63:0] start_sum;
  logic [63:0] end_sum;
  logic [15:0] cnt_inc;
  rled_pkg::phase_t phase_nxt;

  assign hdr_lo       = list_byte[3:0];
  assign hdr_hi       = list_byte[7:4];
  assign hdr_bad      = (hdr_lo > 4'(rled_pkg::MAX_FIELD_BYTES)) ||
                        (hdr_hi > 4'(rled_pkg::MAX_FIELD_BYTES));
  assign hdr_end      = (hdr_lo == 4'd0) || (hdr_hi == 4'd0);
  assign lane_sh      = {st.byte_pos, 3'b000};
  assign byte_lane    = {56'd0, list_byte} << lane_sh;
  assign len_new      = st.len_acc | byte_lane;
  assign off_new      = st.off_acc | byte_lane;
  assign len_left_dec = (st.len_left != 4'd0) ? st.len_left - 4'd1 : 4'd0;
  assign off_left_dec = (st.off_left != 4'd0) ? st.off_left - 4'd1 : 4'd0;

  // sign extension of later runs from the field's own width
  assign ext_sh = {st.off_size[2:0], 3'b000};
  assign ext_on = (st.run_cnt != 16'd0) && (st.off_size != 4'd0) &&
                  (st.off_size < 4'd8) && off_new[6'(ext_sh - 6'd1)];
  assign delta     = ext_on ? (off_new | ({64{1'b1}} << ext_sh)) : off_new;
  assign start_sum = st.run_start + delta;
  assign end_sum   = st.run_start + delta + st.len_acc;
  assign cnt_inc   = (st.run_cnt != 16'hFFFF) ? st.run_cnt + 16'd1 : st.run_cnt;

  always_comb begin
    phase_nxt = st.phase;
    unique case (st.phase)
      rled_pkg::PH_HEADER: begin
        phase_nxt = (hdr_bad || hdr_end) ? rled_pkg::PH_HEADER : rled_pkg::PH_LENGTH;
      end
      rled_pkg::PH_LENGTH: begin
        phase_nxt = (len_left_dec == 4'd0) ? rled_pkg::PH_OFFSET : rled_pkg::PH_LENGTH;
      end
      default: begin
        phase_nxt = (off_left_dec == 4'd0) ? rled_pkg::PH_HEADER : rled_pkg::PH_OFFSET;
      end
    endcase
  end

  always_comb begin
    st_nxt        = st;
    res           = '{kind: rled_pkg::KIND_FRAG, default: '0};
    res.run_num   = st.run_cnt;
    res_valid     = 1'b0;
    unique case (st.phase)
      rled_pkg::PH_HEADER: begin
        if (hdr_bad || hdr_end) begin
          st_nxt    = rled_pkg::STATE_CLEAR;
          res.kind  = hdr_bad ? rled_pkg::KIND_ERR : rled_pkg::KIND_END;
          res_valid = 1'b1;
        end else begin
          st_nxt.len_left = hdr_lo;
          st_nxt.off_left = hdr_hi;
          st_nxt.off_size = hdr_hi;
          st_nxt.byte_pos = 3'd0;
          st_nxt.len_acc  = '0;
          st_nxt.off_acc  = '0;
        end
      end
      rled_pkg::PH_LENGTH: begin
        st_nxt.len_acc  = len_new;
        st_nxt.len_left = len_left_dec;
        st_nxt.byte_pos = (len_left_dec == 4'd0) ? 3'd0 : st.byte_pos + 3'd1;
      end
      default: begin
        st_nxt.off_left = off_left_dec;
        if (off_left_dec == 4'd0) begin
          st_nxt.len_acc   = '0;
          st_nxt.off_acc   = '0;
          st_nxt.byte_pos  = 3'd0;
          st_nxt.run_start = start_sum;
          st_nxt.run_cnt   = cnt_inc;
          res.start        = start_sum;
          res.count        = st.len_acc;
          res.end_clu      = end_sum;
          res.delta        = delta;
          res_valid        = 1'b1;
        end else begin
          st_nxt.off_acc  = off_new;
          st_nxt.byte_pos = st.byte_pos + 3'd1;
        end
      end
    endcase
    st_nxt.phase = phase_nxt;
  end

endmodule

// ===== rtl/core/run_list_extent_decoder.sv =====
// Decodes a run list of cluster extents fed one raw byte per transfer. A header
// byte (low nibble length bytes, high nibble offset bytes) is followed by the
// little-endian length and offset fields; the last field byte of a run yields
// one fragment result with start, count, end and delta. A header with a zero
// nibble yields an end result, a nibble above 8 an error result, and both
// reset the running start and run count. Every byte is registered, decoded in
// one pass (the longest path is the three-operand 64-bit start/end sum), and
// the result lands in an output register. A byte is taken every cycle while
// the result side keeps up.
`include "run_list_extent_decoder_macros.svh"

module run_list_extent_decoder (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         in_list_byte,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         out_result_kind,
  output logic [15:0]        out_run_number,
  output logic signed [63:0] out_start_cluster,
  output logic [63:0]        out_cluster_count,
  output logic signed [63:0] out_end_cluster,
  output logic signed [63:0] out_offset_delta
);

  logic                   s1_valid_r;
  logic [7:0]             s1_byte_r;
  logic                   s1_adv;
  logic                   in_xfer;
  rled_pkg::parse_state_t state_r;
  rled_pkg::parse_state_t state_nxt;
  rled_pkg::result_t      res_nxt;
  rled_pkg::result_t      res_r;
  logic                   res_hit;
  logic                   out_valid_r;

  assign s1_adv   = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !s1_adv;
  assign in_xfer  = in_valid && !in_stall;

  rled_step u_step (
    .st        (state_r),
    .list_byte (s1_byte_r),
    .st_nxt    (state_nxt),
    .res       (res_nxt),
    .res_valid (res_hit)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_xfer) begin
      s1_valid_r <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_byte_r <= in_list_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= rled_pkg::STATE_CLEAR;
    end else if (s1_adv) begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv && res_hit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && res_hit) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_result_kind   = res_r.kind;
  assign out_run_number    = res_r.run_num;
  assign out_start_cluster = $signed(res_r.start);
  assign out_cluster_count = res_r.count;
  assign out_end_cluster   = $signed(res_r.end_clu);
  assign out_offset_delta  = $signed(res_r.delta);

  `RLED_ASSERT_NEXT(a_list_end_clears, clk, rst_n,
                    s1_adv && res_hit && res_nxt.kind != rled_pkg::KIND_FRAG,
                    state_r.run_cnt == 16'd0 && state_r.run_start == 64'd0)
  `RLED_ASSERT_NEXT(a_frag_back_to_header, clk, rst_n,
                    s1_adv && res_hit && res_nxt.kind == rled_pkg::KIND_FRAG,
                    state_r.phase == rled_pkg::PH_HEADER)
  `RLED_ASSERT_NOW(a_frag_end_sum, clk, rst_n,
                   out_valid_r && res_r.kind == rled_pkg::KIND_FRAG,
                   res_r.end_clu == res_r.start + res_r.count)
  `RLED_ASSERT_NOW(a_end_zero_payload, clk, rst_n,
                   out_valid_r && res_r.kind != rled_pkg::KIND_FRAG,
                   res_r.start == 64'd0 && res_r.count == 64'd0 && res_r.delta == 64'd0)
  `RLED_ASSERT_NOW(a_no_result_overrun, clk, rst_n, out_valid_r && out_stall, !s1_adv)

endmodule
